[src/dbfc_pkg.sv]
package dbfc_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OFFSET_W = 10;
    localparam int unsigned BREG_W   = 25;
    localparam int unsigned PROT_W   = 8;

    localparam logic [DATA_W-1:0] BANK_KEY_A = 32'h4567_0123;
    localparam logic [DATA_W-1:0] BANK_KEY_B = 32'hcdef_89ab;
    localparam logic [DATA_W-1:0] OPT_KEY_A  = 32'h0819_2a3b;
    localparam logic [DATA_W-1:0] OPT_KEY_B  = 32'h4c5d_6e7f;
    localparam logic [PROT_W-1:0] PROT_ALL   = 8'hff;

    // shared register offsets
    localparam logic [OFFSET_W-1:0] OFF_ACR      = 10'h000;
    localparam logic [OFFSET_W-1:0] OFF_OPTKEY   = 10'h008;
    localparam logic [OFFSET_W-1:0] OFF_OPTCR    = 10'h018;
    localparam logic [OFFSET_W-1:0] OFF_OPTSR    = 10'h01c;
    localparam logic [OFFSET_W-1:0] OFF_OPTSR_ST = 10'h020;

    // per-bank register offsets, relative to the bank window
    localparam logic [7:0] REL_KEY     = 8'h04;
    localparam logic [7:0] REL_CR      = 8'h0c;
    localparam logic [7:0] REL_SR      = 8'h10;
    localparam logic [7:0] REL_CCR     = 8'h14;
    localparam logic [7:0] REL_PROT    = 8'h38;
    localparam logic [7:0] REL_PROT_ST = 8'h3c;

    // bank register select codes
    localparam logic [2:0] BREG_NONE    = 3'd0;
    localparam logic [2:0] BREG_KEY     = 3'd1;
    localparam logic [2:0] BREG_CR      = 3'd2;
    localparam logic [2:0] BREG_SR      = 3'd3;
    localparam logic [2:0] BREG_CCR     = 3'd4;
    localparam logic [2:0] BREG_PROT    = 3'd5;
    localparam logic [2:0] BREG_PROT_ST = 3'd6;

    localparam logic [1:0] ERASE_NONE   = 2'd0;
    localparam logic [1:0] ERASE_SECTOR = 2'd1;
    localparam logic [1:0] ERASE_BANK   = 2'd2;

    // control register bits
    localparam int unsigned CR_LOCK  = 0;
    localparam int unsigned CR_SER   = 2;
    localparam int unsigned CR_BER   = 3;
    localparam int unsigned CR_START = 7;
    localparam int unsigned CR_SNB_LO = 8;

    // status register bits
    localparam int unsigned SR_EOP    = 16;
    localparam int unsigned SR_WRPERR = 17;
    localparam int unsigned SR_OPERR  = 22;

    localparam logic [BREG_W-1:0] FLAG_MASK = 25'h1ef_0000;
    localparam logic [BREG_W-1:0] CR_KEEP   = 25'h1ef_077f;

    typedef struct packed {
        logic              hit;
        logic              wr;
        logic [2:0]        sel;
        logic [DATA_W-1:0] data;
    } bank_acc_t;

    typedef struct packed {
        logic [DATA_W-1:0] rd_data;
        logic              irq;
        logic [1:0]        erase_kind;
        logic [2:0]        erase_sector;
    } bank_out_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic [1:0]        erase_kind;
        logic              erase_bank_index;
        logic [2:0]        erase_sector_index;
        logic              banks_swapped;
    } resp_t;

endpackage

[src/dbfc_if.sv]
interface dbfc_req_if;
    import dbfc_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, action, offset, write_data, input ready);
    modport sink   (input valid, action, offset, write_data, output ready);
endinterface

interface dbfc_resp_if;
    import dbfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
    logic [1:0]        erase_kind;
    logic              erase_bank_index;
    logic [2:0]        erase_sector_index;
    logic              banks_swapped;

    modport source (output valid, read_data, irq_level, erase_kind, erase_bank_index,
                    erase_sector_index, banks_swapped, input ready);
    modport sink   (input valid, read_data, irq_level, erase_kind, erase_bank_index,
                    erase_sector_index, banks_swapped, output ready);
endinterface

[src/dual_bank_flash_control_regs_core.sv]
// Channel  Dir  Payload
// req      in   action, offset, write_data
// resp     out  read_data, irq_level, erase_kind, erase_bank_index,
//               erase_sector_index, banks_swapped
//
// One request per cycle unless the skid entry is full; its response is registered.
// Decode and register update finish in the accept cycle. A two-entry output
// buffer (result register plus skid) takes one more request while resp stalls;
// req.ready is low only while the skid entry is full. Reset clears the valid
// flags and puts all control and status registers at their power-up values.
module dual_bank_flash_control_regs_core #(
    parameter int unsigned BANK_COUNT       = 2,
    parameter int unsigned SECTORS_PER_BANK = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    dbfc_req_if.sink    req,
    dbfc_resp_if.source resp
);
    import dbfc_pkg::*;

    logic              fire;
    logic              wr;
    logic [DATA_W-1:0] wdata;
    logic              shared_hit;
    logic [2:0]        bsel;
    logic              opt_commit;

    logic [DATA_W-1:0] acr_reg, acr_next;
    logic              opt_locked_reg, opt_locked_next;
    logic              opt_key_seen_reg, opt_key_seen_next;
    logic [DATA_W-1:0] optsr_cur_reg, optsr_cur_next;
    logic [DATA_W-1:0] optsr_stg_reg, optsr_stg_next;
    logic              swap_reg, swap_next;
    logic [DATA_W-1:0] shared_rd;

    bank_acc_t acc  [BANK_COUNT];
    bank_out_t bout [BANK_COUNT];

    resp_t result;
    resp_t out_reg;
    resp_t skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    logic  out_fire;

    assign req.ready = !skid_valid_reg;
    assign fire      = req.valid && req.ready;
    assign wr        = req.action;
    assign wdata     = req.write_data;
    assign out_fire  = out_valid_reg && resp.ready;

    assign shared_hit = (req.offset == OFF_ACR) || (req.offset == OFF_OPTKEY)
                     || (req.offset == OFF_OPTCR) || (req.offset == OFF_OPTSR)
                     || (req.offset == OFF_OPTSR_ST);

    always_comb
    begin
        unique case (req.offset[7:0])
            REL_KEY:     bsel = BREG_KEY;
            REL_CR:      bsel = BREG_CR;
            REL_SR:      bsel = BREG_SR;
            REL_CCR:     bsel = BREG_CCR;
            REL_PROT:    bsel = BREG_PROT;
            REL_PROT_ST: bsel = BREG_PROT_ST;
            default:     bsel = BREG_NONE;
        endcase
    end

    assign opt_commit = fire && wr && (req.offset == OFF_OPTCR) && !opt_locked_reg
                     && wdata[1];

    // shared registers
    always_comb
    begin
        acr_next          = acr_reg;
        opt_locked_next   = opt_locked_reg;
        opt_key_seen_next = opt_key_seen_reg;
        optsr_cur_next    = optsr_cur_reg;
        optsr_stg_next    = optsr_stg_reg;
        swap_next         = swap_reg;
        shared_rd         = '0;

        if (fire)
        begin
            unique case (req.offset)
                OFF_ACR:
                begin
                    if (wr) acr_next = wdata;
                    else    shared_rd = acr_reg;
                end
                OFF_OPTKEY:
                begin
                    if (wr && opt_locked_reg)
                    begin
                        if (!opt_key_seen_reg)
                        begin
                            opt_key_seen_next = (wdata == OPT_KEY_A);
                        end
                        else
                        begin
                            if (wdata == OPT_KEY_B)
                            begin
                                opt_locked_next = 1'b0;
                            end
                            opt_key_seen_next = 1'b0;
                        end
                    end
                end
                OFF_OPTCR:
                begin
                    if (!wr)
                    begin
                        shared_rd = {31'b0, opt_locked_reg};
                    end
                    else if (!opt_locked_reg)
                    begin
                        opt_locked_next = wdata[0];
                        if (wdata[1])
                        begin
                            optsr_cur_next = optsr_stg_reg;
                            swap_next      = optsr_stg_reg[DATA_W-1];
                        end
                    end
                end
                OFF_OPTSR:
                begin
                    if (!wr) shared_rd = optsr_cur_reg;
                end
                OFF_OPTSR_ST:
                begin
                    if (wr) optsr_stg_next = wdata;
                    else    shared_rd = optsr_stg_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acr_reg          <= '0;
            opt_locked_reg   <= 1'b1;
            opt_key_seen_reg <= 1'b0;
            optsr_cur_reg    <= '0;
            optsr_stg_reg    <= '0;
            swap_reg         <= 1'b0;
        end
        else
        begin
            acr_reg          <= acr_next;
            opt_locked_reg   <= opt_locked_next;
            opt_key_seen_reg <= opt_key_seen_next;
            optsr_cur_reg    <= optsr_cur_next;
            optsr_stg_reg    <= optsr_stg_next;
            swap_reg         <= swap_next;
        end
    end

    for (genvar b = 0; b < BANK_COUNT; b++)
    begin : g_bank
        assign acc[b].hit  = fire && !shared_hit && (req.offset[9:8] == 2'(b))
                          && (bsel != BREG_NONE);
        assign acc[b].wr   = wr;
        assign acc[b].sel  = bsel;
        assign acc[b].data = wdata;

        dbfc_bank #(
            .SECTORS_PER_BANK(SECTORS_PER_BANK)
        ) u_bank (
            .clk        (clk),
            .rst_n      (rst_n),
            .acc        (acc[b]),
            .opt_commit (opt_commit),
            .bout       (bout[b])
        );
    end

    always_comb
    begin
        logic [DATA_W-1:0] rd;
        rd                        = shared_rd;
        result.irq_level          = 1'b0;
        result.erase_kind         = ERASE_NONE;
        result.erase_bank_index   = 1'b0;
        result.erase_sector_index = '0;
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            rd               = rd | bout[b].rd_data;
            result.irq_level = result.irq_level | bout[b].irq;
            if (bout[b].erase_kind != ERASE_NONE)
            begin
                result.erase_kind         = bout[b].erase_kind;
                result.erase_bank_index   = 1'(b);
                result.erase_sector_index = bout[b].erase_sector;
            end
        end
        result.read_data     = wr ? '0 : rd;
        result.banks_swapped = swap_next;
    end

    // output buffer: result register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign resp.valid              = out_valid_reg;
    assign resp.read_data          = out_reg.read_data;
    assign resp.irq_level          = out_reg.irq_level;
    assign resp.erase_kind         = out_reg.erase_kind;
    assign resp.erase_bank_index   = out_reg.erase_bank_index;
    assign resp.erase_sector_index = out_reg.erase_sector_index;
    assign resp.banks_swapped      = out_reg.banks_swapped;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !out_valid_reg) |=> out_valid_reg)
        else $error("accepted request produced no response");

    a_no_erase_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !wr) |-> (result.erase_kind == ERASE_NONE))
        else $error("erase issued on a read");

    a_idle_erase_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && resp.erase_kind == ERASE_NONE)
            |-> (!resp.erase_bank_index && resp.erase_sector_index == 3'd0))
        else $error("erase fields set without an erase");

    a_swap_follows_commit: assert property (@(posedge clk) disable iff (!rst_n)
        opt_commit |=> (swap_reg == $past(optsr_stg_reg[DATA_W-1])))
        else $error("bank swap not taken from staged option bytes");

endmodule

[src/dbfc_bank.sv]
module dbfc_bank #(
    parameter int unsigned SECTORS_PER_BANK = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dbfc_pkg::bank_acc_t acc,
    input  logic                opt_commit,
    output dbfc_pkg::bank_out_t bout
);
    import dbfc_pkg::*;

    logic [BREG_W-1:0] ctrl_reg, ctrl_next;
    logic [BREG_W-1:0] status_reg, status_next;
    logic              key_seen_reg, key_seen_next;
    logic [PROT_W-1:0] prot_cur_reg, prot_cur_next;
    logic [PROT_W-1:0] prot_stg_reg, prot_stg_next;
    logic [2:0]        snb;
    logic              snb_bad;

    assign snb     = acc.data[CR_SNB_LO +: 3];
    assign snb_bad = {1'b0, snb} >= 4'(SECTORS_PER_BANK);

    always_comb
    begin
        ctrl_next         = ctrl_reg;
        status_next       = status_reg;
        key_seen_next     = key_seen_reg;
        prot_cur_next     = prot_cur_reg;
        prot_stg_next     = prot_stg_reg;
        bout.rd_data      = '0;
        bout.erase_kind   = ERASE_NONE;
        bout.erase_sector = '0;

        if (opt_commit)
        begin
            prot_cur_next = prot_stg_reg;
        end

        if (acc.hit)
        begin
            unique case (acc.sel)
                BREG_KEY:
                begin
                    if (acc.wr && ctrl_reg[CR_LOCK])
                    begin
                        if (!key_seen_reg)
                        begin
                            key_seen_next = (acc.data == BANK_KEY_A);
                        end
                        else
                        begin
                            if (acc.data == BANK_KEY_B)
                            begin
                                ctrl_next[CR_LOCK] = 1'b0;
                            end
                            key_seen_next = 1'b0;
                        end
                    end
                end
                BREG_CR:
                begin
                    if (!acc.wr)
                    begin
                        bout.rd_data = {7'b0, ctrl_reg};
                    end
                    else if (!ctrl_reg[CR_LOCK])
                    begin
                        ctrl_next = acc.data[BREG_W-1:0] & CR_KEEP;
                        if (acc.data[CR_START])
                        begin
                            // bank erase wins over sector erase
                            if (acc.data[CR_BER])
                            begin
                                if (prot_cur_reg != PROT_ALL)
                                begin
                                    status_next[SR_WRPERR] = 1'b1;
                                end
                                else
                                begin
                                    status_next[SR_EOP] = 1'b1;
                                    bout.erase_kind     = ERASE_BANK;
                                end
                            end
                            else if (acc.data[CR_SER])
                            begin
                                if (snb_bad)
                                begin
                                    status_next[SR_OPERR] = 1'b1;
                                end
                                else if (!prot_cur_reg[snb])
                                begin
                                    status_next[SR_WRPERR] = 1'b1;
                                end
                                else
                                begin
                                    status_next[SR_EOP] = 1'b1;
                                    bout.erase_kind     = ERASE_SECTOR;
                                    bout.erase_sector   = snb;
                                end
                            end
                        end
                    end
                end
                BREG_SR:
                begin
                    if (!acc.wr)
                    begin
                        bout.rd_data = {7'b0, status_reg};
                    end
                end
                BREG_CCR:
                begin
                    if (acc.wr)
                    begin
                        status_next = status_reg & ~(acc.data[BREG_W-1:0] & FLAG_MASK);
                    end
                end
                BREG_PROT:
                begin
                    if (!acc.wr)
                    begin
                        bout.rd_data = {24'b0, prot_cur_reg};
                    end
                end
                BREG_PROT_ST:
                begin
                    if (acc.wr)
                    begin
                        prot_stg_next = acc.data[PROT_W-1:0];
                    end
                    else
                    begin
                        bout.rd_data = {24'b0, prot_stg_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end

        // interrupt reflects the state after this access
        bout.irq = |(status_next & ctrl_next & FLAG_MASK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= BREG_W'(1) << CR_LOCK;
            status_reg   <= '0;
            key_seen_reg <= 1'b0;
            prot_cur_reg <= PROT_ALL;
            prot_stg_reg <= PROT_ALL;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            status_reg   <= status_next;
            key_seen_reg <= key_seen_next;
            prot_cur_reg <= prot_cur_next;
            prot_stg_reg <= prot_stg_next;
        end
    end

endmodule

[sim/dual_bank_flash_control_regs_core_tb.sv]
`timescale 1ns / 1ps

module dual_bank_flash_control_regs_core_tb;
    import dbfc_pkg::*;

    localparam int BANKS       = 2;
    localparam int SECTORS     = 8;
    localparam int ITEM_COUNT  = 1250;
    localparam int QUIET_FROM  = 1100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 200;

    localparam bit ACT_READ  = 1'b0;
    localparam bit ACT_WRITE = 1'b1;

    // tracks the flash register state and the responses it must produce
    class flash_regs_scoreboard;
        logic [DATA_W-1:0] acr;
        bit                opt_locked;
        bit                opt_key_seen;
        logic [BREG_W-1:0] ctl [BANKS];
        logic [BREG_W-1:0] stat [BANKS];
        bit                key_seen [BANKS];
        logic [DATA_W-1:0] opt_cur;
        logic [DATA_W-1:0] opt_staged;
        logic [PROT_W-1:0] prot_cur [BANKS];
        logic [PROT_W-1:0] prot_staged [BANKS];
        bit                swap;

        resp_t expected_q[$];
        int    failures;
        int    mismatches;
        int    reads;
        int    writes;
        int    sector_erases;
        int    bank_erases;
        int    rejected_erases;
        int    swap_commits;

        function new();
            acr          = '0;
            opt_locked   = 1'b1;
            opt_key_seen = 1'b0;
            opt_cur      = '0;
            opt_staged   = '0;
            swap         = 1'b0;
            for (int b = 0; b < BANKS; b++)
            begin
                ctl[b]         = '0;
                ctl[b][CR_LOCK] = 1'b1;
                stat[b]        = '0;
                key_seen[b]    = 1'b0;
                prot_cur[b]    = PROT_ALL;
                prot_staged[b] = PROT_ALL;
            end
        endfunction

        function void note_request(bit wr, logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] v);
            resp_t             r;
            logic [DATA_W-1:0] rd;
            logic [DATA_W-1:0] rel;
            logic [1:0]        kind;
            bit                ebank;
            logic [2:0]        esec;
            logic [2:0]        snb;
            logic [BREG_W-1:0] pend;
            bit                hit;

            rd    = '0;
            kind  = ERASE_NONE;
            ebank = 1'b0;
            esec  = '0;
            hit   = 1'b1;
            if (wr)
                writes++;
            else
                reads++;

            case (off)
                OFF_ACR:
                    if (wr) acr = v; else rd = acr;
                OFF_OPTKEY:
                    if (wr && opt_locked)
                    begin
                        if (!opt_key_seen)
                            opt_key_seen = (v == OPT_KEY_A);
                        else
                        begin
                            if (v == OPT_KEY_B)
                                opt_locked = 1'b0;
                            opt_key_seen = 1'b0;
                        end
                    end
                OFF_OPTCR:
                    if (!wr)
                        rd = DATA_W'(opt_locked);
                    else if (!opt_locked)
                    begin
                        opt_locked = v[0];
                        if (v[1])
                        begin
                            opt_cur = opt_staged;
                            for (int b = 0; b < BANKS; b++)
                                prot_cur[b] = prot_staged[b];
                            if (swap != opt_cur[DATA_W-1])
                                swap_commits++;
                            swap = opt_cur[DATA_W-1];
                        end
                    end
                OFF_OPTSR:
                    if (!wr) rd = opt_cur;
                OFF_OPTSR_ST:
                    if (wr) opt_staged = v; else rd = opt_staged;
                default:
                    hit = 1'b0;
            endcase

            for (int b = 0; !hit && b < BANKS; b++)
            begin
                rel = DATA_W'(off) - DATA_W'(b) * 32'h100;
                hit = 1'b1;
                case (rel)
                    DATA_W'(REL_KEY):
                        if (wr && ctl[b][CR_LOCK])
                        begin
                            if (!key_seen[b])
                                key_seen[b] = (v == BANK_KEY_A);
                            else
                            begin
                                if (v == BANK_KEY_B)
                                    ctl[b][CR_LOCK] = 1'b0;
                                key_seen[b] = 1'b0;
                            end
                        end
                    DATA_W'(REL_CR):
                        if (!wr)
                            rd = DATA_W'(ctl[b]);
                        else if (!ctl[b][CR_LOCK])
                        begin
                            ctl[b] = v[BREG_W-1:0] & CR_KEEP;
                            if (v[CR_START])
                            begin
                                snb = ctl[b][CR_SNB_LO +: 3];
                                // bank erase wins over sector erase
                                if (ctl[b][CR_BER])
                                begin
                                    if (prot_cur[b] != PROT_ALL)
                                    begin
                                        stat[b][SR_WRPERR] = 1'b1;
                                        rejected_erases++;
                                    end
                                    else
                                    begin
                                        stat[b][SR_EOP] = 1'b1;
                                        kind  = ERASE_BANK;
                                        ebank = 1'(b);
                                        bank_erases++;
                                    end
                                end
                                else if (ctl[b][CR_SER])
                                begin
                                    if (int'(snb) >= SECTORS)
                                    begin
                                        stat[b][SR_OPERR] = 1'b1;
                                        rejected_erases++;
                                    end
                                    else if (!prot_cur[b][snb])
                                    begin
                                        stat[b][SR_WRPERR] = 1'b1;
                                        rejected_erases++;
                                    end
                                    else
                                    begin
                                        stat[b][SR_EOP] = 1'b1;
                                        kind  = ERASE_SECTOR;
                                        ebank = 1'(b);
                                        esec  = snb;
                                        sector_erases++;
                                    end
                                end
                            end
                        end
                    DATA_W'(REL_SR):
                        if (!wr) rd = DATA_W'(stat[b]);
                    DATA_W'(REL_CCR):
                        if (wr) stat[b] &= ~(v[BREG_W-1:0] & FLAG_MASK);
                    DATA_W'(REL_PROT):
                        if (!wr) rd = DATA_W'(prot_cur[b]);
                    DATA_W'(REL_PROT_ST):
                        if (wr) prot_staged[b] = v[PROT_W-1:0]; else rd = DATA_W'(prot_staged[b]);
                    default:
                        hit = 1'b0;
                endcase
            end

            pend = '0;
            for (int b = 0; b < BANKS; b++)
                pend |= stat[b] & ctl[b] & FLAG_MASK;

            r.read_data          = wr ? '0 : rd;
            r.irq_level          = |pend;
            r.erase_kind         = kind;
            r.erase_bank_index   = ebank;
            r.erase_sector_index = esec;
            r.banks_swapped      = swap;
            expected_q.push_back(r);
        endfunction

        function void report(string what, resp_t exp, resp_t got);
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s exp rd=%h irq=%b kind=%0d bank=%0d sec=%0d swap=%b", $time,
                         what, exp.read_data, exp.irq_level, exp.erase_kind, exp.erase_bank_index,
                         exp.erase_sector_index, exp.banks_swapped);
            if (mismatches <= 10)
                $display("%0t: %s got rd=%h irq=%b kind=%0d bank=%0d sec=%0d swap=%b", $time,
                         what, got.read_data, got.irq_level, got.erase_kind,
                         got.erase_bank_index, got.erase_sector_index, got.banks_swapped);
        endfunction

        function void check_response(resp_t got);
            resp_t exp;
            bit    bad;

            if (expected_q.size() == 0)
            begin
                report("unexpected response", '0, got);
                return;
            end
            exp = expected_q.pop_front();
            bad = (got.read_data !== exp.read_data)
                || (got.irq_level !== exp.irq_level)
                || (got.erase_kind !== exp.erase_kind)
                || (got.erase_bank_index !== exp.erase_bank_index)
                || (got.erase_sector_index !== exp.erase_sector_index)
                || (got.banks_swapped !== exp.banks_swapped);
            if (bad)
                report("mismatch", exp, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dbfc_req_if  req_ch ();
    dbfc_resp_if resp_ch ();

    dual_bank_flash_control_regs_core #(
        .BANK_COUNT       (BANKS),
        .SECTORS_PER_BANK (SECTORS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .resp  (resp_ch.source)
    );

    flash_regs_scoreboard book;
    resp_t                seen_resp;
    int                   sent;
    int                   cycles;
    bit                   src_gaps;
    bit                   sink_gaps;
    bit                   long_hold;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                     book.expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            seen_resp.read_data          = resp_ch.read_data;
            seen_resp.irq_level          = resp_ch.irq_level;
            seen_resp.erase_kind         = resp_ch.erase_kind;
            seen_resp.erase_bank_index   = resp_ch.erase_bank_index;
            seen_resp.erase_sector_index = resp_ch.erase_sector_index;
            seen_resp.banks_swapped      = resp_ch.banks_swapped;
            book.check_response(seen_resp);
        end
    end

    // response side: random stalls, plus long holds to back the block up
    initial
    begin
        resp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                resp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                resp_ch.ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                resp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                resp_ch.ready <= 1'b1;
            end
            else
                resp_ch.ready <= 1'b1;
        end
    end

    function automatic logic [OFFSET_W-1:0] bank_reg(int b, logic [7:0] rel);
        return OFFSET_W'(b * 32'h100) + OFFSET_W'(rel);
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_mapped_offset();
        int b;

        b = $urandom_range(0, BANKS - 1);
        case ($urandom_range(0, 10))
            0:       return OFF_ACR;
            1:       return OFF_OPTKEY;
            2:       return OFF_OPTCR;
            3:       return OFF_OPTSR;
            4:       return OFF_OPTSR_ST;
            5:       return bank_reg(b, REL_KEY);
            6:       return bank_reg(b, REL_CR);
            7:       return bank_reg(b, REL_SR);
            8:       return bank_reg(b, REL_CCR);
            9:       return bank_reg(b, REL_PROT);
            default: return bank_reg(b, REL_PROT_ST);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back requests
    task automatic send_request(bit wr, logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] data);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= wr;
        req_ch.offset     <= off;
        req_ch.write_data <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request(wr, off, data);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] data);
        send_request(ACT_WRITE, off, data);
    endtask

    task automatic read_reg(logic [OFFSET_W-1:0] off);
        send_request(ACT_READ, off, $urandom);
    endtask

    function automatic logic [DATA_W-1:0] erase_word(bit ber, bit ser, logic [2:0] snb);
        logic [DATA_W-1:0] w;

        w = $urandom;
        w[CR_LOCK]           = ($urandom_range(0, 9) == 0);
        w[CR_BER]            = ber;
        w[CR_SER]            = ser;
        w[CR_START]          = ($urandom_range(0, 9) < 7);
        w[CR_SNB_LO +: 3]    = snb;
        return w;
    endfunction

    task automatic unlock_bank(int b);
        write_reg(bank_reg(b, REL_KEY), BANK_KEY_A);
        write_reg(bank_reg(b, REL_KEY), ($urandom_range(0, 9) == 0) ? $urandom : BANK_KEY_B);
    endtask

    task automatic option_sequence();
        logic [DATA_W-1:0] w;

        write_reg(OFF_OPTKEY, OPT_KEY_A);
        write_reg(OFF_OPTKEY, ($urandom_range(0, 9) == 0) ? $urandom : OPT_KEY_B);
        write_reg(OFF_OPTSR_ST, $urandom);
        for (int b = 0; b < BANKS; b++)
            write_reg(bank_reg(b, REL_PROT_ST),
                      ($urandom_range(0, 9) < 6) ? DATA_W'(PROT_ALL) : $urandom);
        w    = $urandom;
        w[1] = ($urandom_range(0, 9) < 8);
        write_reg(OFF_OPTCR, w);
        if ($urandom_range(0, 1))
            read_reg(OFF_OPTSR);
    endtask

    task automatic directed_requests();
        read_reg(bank_reg(0, REL_CR));
        write_reg(bank_reg(0, REL_CR), 32'h0000_0088);          // locked: ignored
        write_reg(bank_reg(0, REL_KEY), BANK_KEY_A);
        write_reg(bank_reg(0, REL_KEY), 32'h1234_5678);         // wrong key restarts
        write_reg(bank_reg(0, REL_KEY), BANK_KEY_A);
        write_reg(bank_reg(0, REL_KEY), BANK_KEY_B);
        write_reg(bank_reg(0, REL_KEY), BANK_KEY_A);            // already open: ignored
        write_reg(bank_reg(0, REL_CR), 32'h01ef_008c);          // BER+SER+START, irq enables
        read_reg(bank_reg(0, REL_SR));
        write_reg(bank_reg(0, REL_CCR), 32'hffff_ffff);
        write_reg(bank_reg(0, REL_CR), 32'h0000_0784);          // sector 7
        write_reg(bank_reg(0, REL_SR), 32'hffff_ffff);          // read-only
        write_reg(bank_reg(0, REL_CR), 32'h0000_0080);          // START alone
        write_reg(OFF_OPTCR, 32'h0000_0002);                    // option locked: ignored
        write_reg(OFF_OPTKEY, OPT_KEY_A);
        write_reg(OFF_OPTKEY, OPT_KEY_B);
        write_reg(OFF_OPTSR_ST, 32'h8000_0000);
        write_reg(bank_reg(0, REL_PROT_ST), 32'hffff_ff7f);
        write_reg(OFF_OPTCR, 32'h0000_0002);                    // commit, stay unlocked
        write_reg(bank_reg(0, REL_CR), 32'h0000_0784);          // protected sector
        write_reg(bank_reg(0, REL_CR), 32'h0000_0088);          // protected bank
        write_reg(OFF_OPTCR, 32'hffff_fffd);                    // relock, no commit
        read_reg(bank_reg(0, REL_PROT));
        write_reg(OFF_ACR, 32'hffff_ffff);
        read_reg(10'h3ff);
    endtask

    task automatic random_requests();
        int b;
        int pick;

        while (sent < ITEM_COUNT)
        begin
            if (sent >= QUIET_FROM)
            begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                src_gaps  = 1'($urandom_range(0, 1));
                sink_gaps = 1'($urandom_range(0, 1));
            end
            if (sent >= 500 && sent < 520 && !long_hold && cycles > 0)
                long_hold = 1'b1;

            b    = $urandom_range(0, BANKS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 14)
                unlock_bank(b);
            else if (pick < 44)
            begin
                write_reg(bank_reg(b, REL_CR),
                          erase_word($urandom_range(0, 9) < 3, $urandom_range(0, 9) < 7,
                                     3'($urandom_range(0, 7))));
                if ($urandom_range(0, 1))
                    read_reg(bank_reg(b, REL_SR));
            end
            else if (pick < 53)
                write_reg(bank_reg(b, REL_CCR), $urandom_range(0, 1) ? 32'hffff_ffff : $urandom);
            else if (pick < 61)
                option_sequence();
            else if (pick < 82)
                read_reg(pick_mapped_offset());
            else if (pick < 92)
                send_request(1'($urandom_range(0, 1)), OFFSET_W'($urandom_range(0, 1023)),
                             $urandom);
            else
                write_reg(pick_mapped_offset(), $urandom);
        end
    endtask

    initial
    begin
        book              = new();
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_READ;
        req_ch.offset     = '0;
        req_ch.write_data = '0;
        src_gaps          = 1'b0;
        sink_gaps         = 1'b0;
        long_hold         = 1'b0;
        sent              = 0;
        cycles            = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_requests();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        random_requests();
        req_ch.valid <= 1'b0;

        while (book.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        book.failures += book.expected_q.size();

        $display("Run covered %0d requests (%0d reads, %0d writes) in %0d cycles.",
                 sent, book.reads, book.writes, cycles);
        $display("Erases: %0d sector, %0d bank, %0d rejected; %0d bank swap changes.",
                 book.sector_erases, book.bank_erases, book.rejected_erases,
                 book.swap_commits);
        if (book.failures == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d failures", book.failures);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
